// ===== sv/dnv_pkg.sv =====
// ----------------------------------------------------------------------------
// dnv_pkg
// Shared types and constants for the domain name validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dnv_pkg;

    localparam int NAME_LEN_W  = 9;
    localparam int LABEL_MAX_W = 7;
    localparam int LABEL_CNT_W = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    localparam logic [NAME_LEN_W-1:0]  NAME_LEN_SAT  = 9'd511;
    localparam logic [LABEL_CNT_W-1:0] LABEL_CNT_SAT = 8'd255;

    localparam logic [NAME_LEN_W-1:0]  MAX_NAME_LENGTH_RST  = 9'd253;
    localparam logic [LABEL_MAX_W-1:0] MAX_LABEL_LENGTH_RST = 7'd63;

    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_NAME_LENGTH  = 1'd0,
        REG_MAX_LABEL_LENGTH = 1'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_EMPTY       = 4'd1,
        ST_TRAILING    = 4'd2,
        ST_TOO_LONG    = 4'd3,
        ST_NON_ASCII   = 4'd4,
        ST_EMPTY_LABEL = 4'd5,
        ST_LONG_LABEL  = 4'd6,
        ST_HYPHEN_EDGE = 4'd7,
        ST_BAD_CHAR    = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_name;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [NAME_LEN_W-1:0] name_length;
    } result_t;

    typedef struct packed {
        logic [NAME_LEN_W-1:0]  max_name_length;
        logic [LABEL_MAX_W-1:0] max_label_length;
    } limits_t;

endpackage

`default_nettype wire

// ===== sv/dnv_if.sv =====
// ----------------------------------------------------------------------------
// dnv_in_if / dnv_out_if
// Valid/ready channels for name bytes and validation results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dnv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_name;

    modport source (output valid, output char_byte, output has_char,
                    output end_of_name, input ready);
    modport sink   (input valid, input char_byte, input has_char,
                    input end_of_name, output ready);
endinterface

interface dnv_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [8:0] name_length;

    modport source (output valid, output status, output name_length, input ready);
    modport sink   (input valid, input status, input name_length, output ready);
endinterface

`default_nettype wire

// ===== sv/dnv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dnv_cfg_regs
// Name and label length limit registers, write-only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dnv_cfg_regs
    import dnv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output limits_t                     limits
);

    limits_t limits_reg;
    limits_t limits_next;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MAX_NAME_LENGTH:
                    limits_next.max_name_length = cfg_data[NAME_LEN_W-1:0];
                REG_MAX_LABEL_LENGTH:
                    limits_next.max_label_length = cfg_data[LABEL_MAX_W-1:0];
                default:
                    limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_name_length  <= MAX_NAME_LENGTH_RST;
            limits_reg.max_label_length <= MAX_LABEL_LENGTH_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

`default_nettype wire

// ===== sv/dnv_scan.sv =====
// ----------------------------------------------------------------------------
// dnv_scan
// Per-name scan state; folds one byte per cycle while advance is high and forms the status at end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dnv_scan
    import dnv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire item_t   item,
    input  wire limits_t limits,
    output result_t      result
);

    typedef struct packed {
        logic                   seen_text;
        logic [NAME_LEN_W-1:0]  pending_space_count;
        logic [NAME_LEN_W-1:0]  kept_length;
        logic [LABEL_CNT_W-1:0] label_length;
        logic                   label_starts_hyphen;
        logic                   last_was_hyphen;
        logic [1:0]             trailing_dot_count;
        logic                   label_has_bad_char;
        status_t                first_label_error;
        logic                   non_ascii_seen;
    } scan_state_t;

    scan_state_t state_reg;
    scan_state_t state_next;

    function automatic status_t label_code(input logic [LABEL_CNT_W-1:0] len,
                                           input logic [LABEL_MAX_W-1:0] max_len,
                                           input logic starts_hy,
                                           input logic ends_hy,
                                           input logic bad);
        status_t code;
        code = ST_OK;
        if (len == '0)
            code = ST_EMPTY_LABEL;
        else if (len > {1'b0, max_len})
            code = ST_LONG_LABEL;
        else if (starts_hy || ends_hy)
            code = ST_HYPHEN_EDGE;
        else if (bad)
            code = ST_BAD_CHAR;
        return code;
    endfunction

    logic [7:0]             c;
    logic                   is_space;
    logic                   is_dot;
    logic                   is_hyphen;
    logic                   is_ldh;
    logic                   pend_nz;
    logic [LABEL_CNT_W+1:0] label_sum;
    logic [LABEL_CNT_W-1:0] label1;
    logic                   last1;
    logic                   bad1;
    logic [1:0]             tdc1;
    logic                   rel1;
    logic [1:0]             kept_add;
    logic [NAME_LEN_W+1:0]  kept_sum;
    logic [NAME_LEN_W:0]    pend_sum;
    status_t                code;
    status_t                first_err;
    scan_state_t            a;

    always_comb
    begin
        c         = item.char_byte;
        is_space  = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        is_dot    = (c == CHAR_DOT);
        is_hyphen = (c == CHAR_HYPHEN);
        is_ldh    = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                    (c >= "a" && c <= "z") || is_hyphen;

        // Held whitespace is committed as bad characters once text follows.
        pend_nz   = (state_reg.pending_space_count != '0);
        label_sum = {2'b00, state_reg.label_length} +
                    {1'b0, state_reg.pending_space_count};
        label1    = (label_sum > {2'b00, LABEL_CNT_SAT}) ? LABEL_CNT_SAT :
                    label_sum[LABEL_CNT_W-1:0];
        last1     = pend_nz ? 1'b0 : state_reg.last_was_hyphen;
        bad1      = state_reg.label_has_bad_char | pend_nz;
        tdc1      = pend_nz ? 2'd0 : state_reg.trailing_dot_count;
        rel1      = pend_nz && (state_reg.trailing_dot_count != 2'd0);
        pend_sum  = {1'b0, state_reg.pending_space_count} + {{NAME_LEN_W{1'b0}}, 1'b1};

        kept_add  = {1'b0, rel1} + {1'b0, (tdc1 != 2'd0)} + {1'b0, !is_dot};
        kept_sum  = {2'b00, state_reg.kept_length} +
                    {2'b00, state_reg.pending_space_count} + {{NAME_LEN_W{1'b0}}, kept_add};

        code = ST_OK;
        a    = state_reg;
        if (item.has_char)
        begin
            if (is_space)
            begin
                if (state_reg.seen_text)
                    a.pending_space_count = (pend_sum > {1'b0, NAME_LEN_SAT}) ?
                                            NAME_LEN_SAT : pend_sum[NAME_LEN_W-1:0];
            end
            else
            begin
                a.seen_text           = 1'b1;
                a.pending_space_count = '0;
                a.non_ascii_seen      = state_reg.non_ascii_seen | c[7];
                a.kept_length         = (kept_sum > {2'b00, NAME_LEN_SAT}) ?
                                        NAME_LEN_SAT : kept_sum[NAME_LEN_W-1:0];
                if (is_dot)
                begin
                    code = label_code(label1, limits.max_label_length,
                                      state_reg.label_starts_hyphen, last1, bad1);
                    if (state_reg.first_label_error == ST_OK)
                        a.first_label_error = code;
                    a.label_length        = '0;
                    a.label_starts_hyphen = 1'b0;
                    a.last_was_hyphen     = 1'b0;
                    a.label_has_bad_char  = 1'b0;
                    a.trailing_dot_count  = (tdc1 >= 2'd2) ? 2'd2 : tdc1 + 2'd1;
                end
                else
                begin
                    a.trailing_dot_count = 2'd0;
                    if (label1 == '0)
                        a.label_starts_hyphen = is_hyphen;
                    a.last_was_hyphen    = is_hyphen;
                    a.label_has_bad_char = bad1 | !is_ldh;
                    a.label_length       = (label1 == LABEL_CNT_SAT) ? LABEL_CNT_SAT :
                                           label1 + {{(LABEL_CNT_W-1){1'b0}}, 1'b1};
                end
            end
        end

        // End of name: close the last label unless a dot is held.
        first_err = a.first_label_error;
        if (a.trailing_dot_count == 2'd0 && a.seen_text && first_err == ST_OK)
            first_err = label_code(a.label_length, limits.max_label_length,
                                   a.label_starts_hyphen, a.last_was_hyphen,
                                   a.label_has_bad_char);

        result.name_length = a.kept_length;
        if (!a.seen_text)
        begin
            result.status      = ST_EMPTY;
            result.name_length = '0;
        end
        else if (a.trailing_dot_count >= 2'd2 ||
                 (a.trailing_dot_count == 2'd1 && a.kept_length == '0))
            result.status = ST_TRAILING;
        else if (a.kept_length > limits.max_name_length)
            result.status = ST_TOO_LONG;
        else if (a.non_ascii_seen)
            result.status = ST_NON_ASCII;
        else
            result.status = first_err;

        state_next = state_reg;
        if (advance)
            state_next = item.end_of_name ? scan_state_t'('0) : a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.end_of_name) |=>
            (!state_reg.seen_text && state_reg.kept_length == '0 &&
             state_reg.first_label_error == ST_OK))
        else $error("scan state not cleared after end of name");

endmodule

`default_nettype wire

// ===== sv/domain_name_validator.sv =====
// ----------------------------------------------------------------------------
// domain_name_validator
// Streaming host name check (letters, digits, hyphen) with trimming.
// ----------------------------------------------------------------------------
// Result path: the request carrying end_of_name goes from the input register into the result register.
// Throughput: one byte per cycle; input register, scan logic, result register.
// A held result stalls only items that end a name.
// Reset: rst_n clears scan state and handshakes; limits return to 253 / 63.
`timescale 1ns / 1ps
`default_nettype none

module domain_name_validator
    import dnv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    dnv_in_if.sink                      in_ch,
    dnv_out_if.source                   out_ch,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    limits_t limits;
    result_t scan_result;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    logic    s1_adv;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;
    logic    in_take;

    dnv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    dnv_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .item    (s1_item_reg),
        .limits  (limits),
        .result  (scan_result)
    );

    // Only an end-of-name request needs room in the result register.
    assign s1_adv      = s1_valid_reg &&
                         !(s1_item_reg.end_of_name && out_valid_reg && !out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ch.ready)
            s1_valid_next = in_ch.valid;

        out_valid_next = out_valid_reg && !out_ch.ready;
        if (s1_adv && s1_item_reg.end_of_name)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.char_byte   <= in_ch.char_byte;
            s1_item_reg.has_char    <= in_ch.has_char;
            s1_item_reg.end_of_name <= in_ch.end_of_name;
        end
        if (s1_adv && s1_item_reg.end_of_name)
            out_result_reg <= scan_result;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_result_reg.status;
    assign out_ch.name_length = out_result_reg.name_length;

    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with result register empty");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_item_reg.end_of_name) |=> out_valid_reg)
        else $error("end of name did not produce a result");

    a_empty_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.status == ST_EMPTY) |->
            (out_result_reg.name_length == '0))
        else $error("empty name reported with nonzero length");

endmodule

`default_nettype wire
